FILE: src/grid_path_reachability_dfs_unit_macros.svh
// assertion macros for the grid path reachability unit
// no dependencies; included by the rtl files that carry assertions
`ifndef GRID_PATH_REACHABILITY_DFS_UNIT_MACROS_SVH
`define GRID_PATH_REACHABILITY_DFS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GPR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grid path reachability: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grid path reachability: next-cycle check failed");

`endif

FILE: src/gprdfs_pkg.sv
// shared types and constants for the grid path reachability unit
// no dependencies
package gprdfs_pkg;

    // maze geometry
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MAX_ROWS   = 2 ** ROW_W;
    localparam int MAX_COLS   = 2 ** COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int LIM_W      = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

    // operation codes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // one maze cell coordinate, packed so it doubles as a map address
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cell_t;

    // search sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CHECK,
        ST_PROBE,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

FILE: src/grid_path_reachability_dfs_unit.sv
// Load beats may follow back to back; they give no result. A search handles each popped
// cell that is not the target by pop read, compare, four map probes and write-back, and
// a popped target by pop read and compare; the result is posted once the target is reached
// or the stack runs empty.
// Reset clears the sequencer, stack count, output beat and the limits (64, 64);
// the map and stack memories are not cleared and hold nothing until written.
`include "grid_path_reachability_dfs_unit_macros.svh"

module grid_path_reachability_dfs_unit
    import gprdfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [ROW_W-1:0]     s_cell_row,
    input  logic [COL_W-1:0]     s_cell_col,
    input  logic                 s_cell_open,
    input  logic [ROW_W-1:0]     s_start_row,
    input  logic [COL_W-1:0]     s_start_col,
    input  logic [ROW_W-1:0]     s_end_row,
    input  logic [COL_W-1:0]     s_end_col,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_path_found,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIM_W-1:0]     cfg_data
);

    // memories: open map (1 bit per cell) and pending stack
    logic  map_mem   [CELL_COUNT];
    cell_t stack_mem [CELL_COUNT];

    logic              map_we, map_wd, map_q;
    logic [ADDR_W-1:0] map_wa, map_ra;
    logic              stack_we;
    logic [ADDR_W-1:0] stack_wa, stack_ra;
    cell_t             stack_wd, stack_q;

    // registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LIM_W-1:0]  rows_reg, rows_next;
    logic [LIM_W-1:0]  cols_reg, cols_next;
    cell_t             cur_reg, cur_next;
    cell_t             end_reg, end_next;
    cell_t             probe_cell_reg, probe_cell_next;
    logic              probe_vld_reg, probe_vld_next;
    logic [1:0]        probe_k_reg, probe_k_next;
    logic              found_reg, found_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;

    // combinational helpers
    logic [LIM_W-1:0]  row_lim, col_lim;
    logic [LIM_W-1:0]  nb_row, nb_col;
    logic              nb_exists, nb_ok;
    logic              start_inside;
    logic [CNT_W-1:0]  cnt_dec;
    logic              out_load;
    cell_t             start_cell, end_cell, load_cell;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_path_found = m_found_reg;

    assign start_cell = '{row: s_start_row, col: s_start_col};
    assign end_cell   = '{row: s_end_row,   col: s_end_col};
    assign load_cell  = '{row: s_cell_row,  col: s_cell_col};

    // effective area limits, clamped to the map size
    assign row_lim = (rows_reg > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : rows_reg;
    assign col_lim = (cols_reg > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS) : cols_reg;

    assign start_inside = (LIM_W'(s_start_row) < row_lim) && (LIM_W'(s_start_col) < col_lim);
    assign cnt_dec      = count_reg - CNT_W'(1);

    // neighbor of the current cell in east, south, west, north order
    always_comb begin
        nb_row    = LIM_W'(cur_reg.row);
        nb_col    = LIM_W'(cur_reg.col);
        nb_exists = 1'b1;
        case (probe_k_reg)
            2'd0: begin
                nb_col = LIM_W'(cur_reg.col) + LIM_W'(1);
            end
            2'd1: begin
                nb_row = LIM_W'(cur_reg.row) + LIM_W'(1);
            end
            2'd2: begin
                nb_exists = (cur_reg.col != '0);
                nb_col    = LIM_W'(cur_reg.col) - LIM_W'(1);
            end
            2'd3: begin
                nb_exists = (cur_reg.row != '0);
                nb_row    = LIM_W'(cur_reg.row) - LIM_W'(1);
            end
            default: begin
                nb_exists = 1'b0;
            end
        endcase
        nb_ok = nb_exists && (nb_row < row_lim) && (nb_col < col_lim);
    end

    // sequencer: next state, memory ports and register updates
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        probe_cell_next = probe_cell_reg;
        probe_vld_next  = 1'b0;
        probe_k_next    = probe_k_reg;
        found_next      = found_reg;
        out_load        = 1'b0;
        map_we          = 1'b0;
        map_wa          = load_cell;
        map_wd          = 1'b0;
        map_ra          = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
        stack_we        = 1'b0;
        stack_wa        = count_reg[ADDR_W-1:0];
        stack_wd        = probe_cell_reg;
        stack_ra        = cnt_dec[ADDR_W-1:0];

        // configuration beat
        if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_next = cfg_data;
                REG_COLS_IN_USE: cols_next = cfg_data;
                default: begin
                end
            endcase
        end

        // write-back of the previous probe: push and close an open neighbor
        if (probe_vld_reg && map_q) begin
            map_we = 1'b0 | 1'b1;
            map_wa = probe_cell_reg;
            map_wd = 1'b0;
            if (count_reg < CNT_W'(CELL_COUNT)) begin
                stack_we   = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_LOAD) begin
                        map_we = 1'b1;
                        map_wa = load_cell;
                        map_wd = s_cell_open;
                    end else begin
                        stack_we   = 1'b1;
                        stack_wa   = '0;
                        stack_wd   = start_cell;
                        count_next = CNT_W'(1);
                        end_next   = end_cell;
                        map_we     = start_inside;
                        map_wa     = start_cell;
                        map_wd     = 1'b0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                count_next = cnt_dec;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cur_next = stack_q;
                if (stack_q == end_reg) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    probe_k_next = 2'd0;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                probe_vld_next  = nb_ok;
                probe_cell_next = '{row: nb_row[ROW_W-1:0], col: nb_col[COL_W-1:0]};
                probe_k_next    = probe_k_reg + 2'd1;
                if (probe_k_reg == 2'd3) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (count_next == '0) begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output beat register
        m_found_next = out_load ? found_reg : m_found_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rows_reg      <= LIM_W'(MAX_ROWS);
            cols_reg      <= LIM_W'(MAX_COLS);
            probe_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            probe_vld_reg <= probe_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        probe_cell_reg <= probe_cell_next;
        probe_k_reg    <= probe_k_next;
        found_reg      <= found_next;
        m_found_reg    <= m_found_next;
    end

    // open map memory, registered read
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_q <= map_mem[map_ra];
    end

    // pending stack memory, registered read
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_q <= stack_mem[stack_ra];
    end

    // checks
    `GPR_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CELL_COUNT))
    `GPR_ASSERT_SAME(a_check_after_pop, aclk, aresetn, state_reg == ST_CHECK, $past(state_reg) == ST_POP)
    `GPR_ASSERT_SAME(a_probe_in_walk, aclk, aresetn, probe_vld_reg, state_reg == ST_PROBE || state_reg == ST_DRAIN)
    `GPR_ASSERT_SAME(a_map_write_window, aclk, aresetn, map_we, state_reg == ST_IDLE || state_reg == ST_PROBE || state_reg == ST_DRAIN)
    `GPR_ASSERT_NEXT(a_done_posts, aclk, aresetn, state_reg == ST_DONE && !m_valid_reg, m_valid_reg && m_found_reg == $past(found_reg))

endmodule
